// ----- sv/ciwc_pkg.sv -----
// Shared constants, types and helper functions of the word counter.
`default_nettype none
package ciwc_pkg;

  localparam int MAX_WORDS_DEF = 128;
  localparam int MAX_LEN_DEF   = 32;

  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_COMMA  = 8'd44;
  localparam logic [7:0] CH_PERIOD = 8'd46;
  localparam logic [7:0] CH_LOW_A  = 8'd97;
  localparam logic [7:0] CH_LOW_Z  = 8'd122;
  localparam logic [7:0] CASE_OFS  = 8'd32;

  localparam logic [9:0] HITS_MAX = 10'd1023;

  localparam logic [1:0] ST_EXISTING = 2'd0;
  localparam logic [1:0] ST_NEW      = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  typedef struct packed {
    logic load;
    logic rotate;
  } cell_ctrl_t;

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_COMMA) || (c == CH_PERIOD);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
      r = c - CASE_OFS;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/case_insensitive_word_counter.sv -----
// Top level of the case-insensitive word frequency counter.
//
// Text bytes arrive on the char channel (char_valid, char_ready, char_in).
// Bytes other than space, comma and period build the open word, folded to
// upper case, in a chain of byte cells. A separator closes the word, which
// is then searched in the word table entry by entry: the entry's length and
// count are read and its length checked, then the chain is rotated past the
// stored bytes to compare them when the lengths agree. A new word is copied
// into the table, or reported with a full status when the table is full.
// A closing separator that starts a search holds off new bytes until the
// result word appears on the result channel. Empty tokens give no result;
// an overlong word gives a too-long result. Reset clears the table fill count,
// the open word and the longest length; table contents need no clearing.
// A result waits in its output register while result_ready is low, and the
// block holds char_ready low for as long as that result waits.
`default_nettype none
module case_insensitive_word_counter
  import ciwc_pkg::*;
#(
  parameter int MAX_WORDS = MAX_WORDS_DEF,
  parameter int MAX_LEN   = MAX_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       char_valid,
  output logic            char_ready,
  input  wire logic [7:0] char_in,
  output logic            result_valid,
  input  wire logic       result_ready,
  output logic [6:0]      slot,
  output logic [9:0]      hits,
  output logic [1:0]      status,
  output logic [5:0]      word_length,
  output logic [5:0]      longest
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int UW = $clog2(MAX_WORDS + 1);
  localparam int SW = $clog2(MAX_WORDS);
  localparam int AW = $clog2(MAX_WORDS * MAX_LEN);
  localparam int IW = $clog2(MAX_LEN);
  localparam int MW = LW + 10;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_META = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_HIT  = 3'd4;
  localparam logic [2:0] S_COPY = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]    state;
  logic [LW-1:0] cur_len;
  logic          ovf;
  logic [LW-1:0] wlen;
  logic [UW-1:0] used;
  logic [UW-1:0] e;
  logic [LW-1:0] cnt;
  logic          mism;
  logic [LW-1:0] longest_seen;

  logic [7:0]    cells [MAX_LEN];
  cell_ctrl_t    cctrl [MAX_LEN];
  logic          rot;
  logic          load;
  logic [7:0]    load_byte;

  logic          w_we, w_re;
  logic [AW-1:0] w_waddr, w_raddr, base;
  logic [7:0]    w_rdata;
  logic          m_we, m_re;
  logic [MW-1:0] m_wdata, m_rdata;
  logic [9:0]    old_hits, new_hits;

  logic          ofree, acc, sep, mism_fin;
  logic          res_load;
  logic [6:0]    res_slot;
  logic [9:0]    res_hits;
  logic [1:0]    res_status;
  logic [5:0]    res_len;

  assign ofree      = !result_valid || result_ready;
  assign char_ready = (state == S_IDLE) && ofree;
  assign acc        = char_valid && char_ready;
  assign sep        = is_sep(char_in);
  assign load_byte  = fold(char_in);
  assign load       = acc && !sep && (cur_len < LW'(MAX_LEN));
  assign base       = AW'(e * MAX_LEN);
  assign old_hits   = m_rdata[9:0];
  assign new_hits   = (old_hits == HITS_MAX) ? HITS_MAX : old_hits + 10'd1;
  assign mism_fin   = mism || ((cnt != '0) && (cnt - LW'(1) < wlen) &&
                               (w_rdata != cells[0]));

  genvar gi;
  generate
    for (gi = 0; gi < MAX_LEN; gi++) begin : g_cell
      assign cctrl[gi].load   = load && (cur_len[IW-1:0] == IW'(gi));
      assign cctrl[gi].rotate = rot;
      ciwc_cell u_cell (
        .clk       (clk),
        .ctrl      (cctrl[gi]),
        .load_data (load_byte),
        .from_next (cells[(gi + 1) % MAX_LEN]),
        .value     (cells[gi])
      );
    end
  endgenerate

  ciwc_ram #(.WIDTH(8), .DEPTH(MAX_WORDS * MAX_LEN)) u_words (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (cells[0]),
    .re    (w_re),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  ciwc_ram #(.WIDTH(MW), .DEPTH(MAX_WORDS)) u_meta (
    .clk   (clk),
    .we    (m_we),
    .waddr (e[SW-1:0]),
    .wdata (m_wdata),
    .re    (m_re),
    .raddr (e[SW-1:0]),
    .rdata (m_rdata)
  );

  always_comb begin
    rot        = 1'b0;
    w_we       = 1'b0;
    w_re       = 1'b0;
    w_waddr    = base + AW'(cnt);
    w_raddr    = base + AW'(cnt);
    m_we       = 1'b0;
    m_re       = 1'b0;
    m_wdata    = {wlen, new_hits};
    res_load   = 1'b0;
    res_slot   = 7'(e);
    res_hits   = new_hits;
    res_status = ST_EXISTING;
    res_len    = 6'(wlen);
    unique case (state)
      S_IDLE: begin
        if (acc && sep && ovf) begin
          res_load   = 1'b1;
          res_slot   = '0;
          res_hits   = '0;
          res_status = ST_TOO_LONG;
          res_len    = 6'(MAX_LEN);
        end
      end
      S_SCAN: begin
        if (e == used) begin
          if (used == UW'(MAX_WORDS) && ofree) begin
            res_load   = 1'b1;
            res_slot   = '0;
            res_hits   = '0;
            res_status = ST_FULL;
          end
        end else begin
          m_re = 1'b1;
        end
      end
      S_META: begin
      end
      S_CMP: begin
        w_re = cnt < LW'(MAX_LEN);
        rot  = cnt != '0;
      end
      S_HIT: begin
        if (ofree) begin
          m_we     = 1'b1;
          res_load = 1'b1;
        end
      end
      S_COPY: begin
        rot  = 1'b1;
        w_we = cnt < wlen;
      end
      S_DONE: begin
        if (ofree) begin
          m_we       = 1'b1;
          m_wdata    = {wlen, 10'd1};
          res_load   = 1'b1;
          res_hits   = 10'd1;
          res_status = ST_NEW;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cur_len      <= '0;
      ovf          <= 1'b0;
      used         <= '0;
      longest_seen <= '0;
      result_valid <= 1'b0;
    end else begin
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (!sep) begin
              if (cur_len < LW'(MAX_LEN)) begin
                cur_len <= cur_len + LW'(1);
              end else begin
                ovf <= 1'b1;
              end
            end else if (ovf) begin
              ovf     <= 1'b0;
              cur_len <= '0;
            end else if (cur_len != '0) begin
              wlen    <= cur_len;
              cur_len <= '0;
              e       <= '0;
              if (cur_len > longest_seen) begin
                longest_seen <= cur_len;
              end
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cnt  <= '0;
          mism <= 1'b0;
          if (e == used) begin
            if (used != UW'(MAX_WORDS)) begin
              state <= S_COPY;
            end else if (ofree) begin
              state <= S_IDLE;
            end
          end else begin
            state <= S_META;
          end
        end
        S_META: begin
          if (m_rdata[MW-1:10] == wlen) begin
            state <= S_CMP;
          end else begin
            e     <= e + UW'(1);
            state <= S_SCAN;
          end
        end
        S_CMP: begin
          mism <= mism_fin;
          cnt  <= cnt + LW'(1);
          if (cnt == LW'(MAX_LEN)) begin
            if (mism_fin) begin
              e     <= e + UW'(1);
              state <= S_SCAN;
            end else begin
              state <= S_HIT;
            end
          end
        end
        S_HIT: begin
          if (ofree) begin
            state <= S_IDLE;
          end
        end
        S_COPY: begin
          cnt <= cnt + LW'(1);
          if (cnt == LW'(MAX_LEN - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (ofree) begin
            used  <= used + UW'(1);
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      slot        <= res_slot;
      hits        <= res_hits;
      status      <= res_status;
      word_length <= res_len;
      longest     <= 6'(longest_seen);
    end
  end

`ifndef SYNTHESIS
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    used <= UW'(MAX_WORDS)) else $error("table fill count out of range");
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    cur_len <= LW'(MAX_LEN)) else $error("open word length out of range");
  a_hits_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_EXISTING || status == ST_NEW) |-> hits != '0)
    else $error("counted word reported with zero hits");
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !char_ready)
    else $error("byte accepted during table search");
`endif

endmodule
`default_nettype wire

// ----- sv/ciwc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ciwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/ciwc_cell.sv -----
// One byte cell of the rotating chain that holds the open word.
`default_nettype none
module ciwc_cell
  import ciwc_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic [7:0] load_data,
  input  wire logic [7:0] from_next,
  output logic      [7:0] value
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      value <= load_data;
    end else if (ctrl.rotate) begin
      value <= from_next;
    end
  end

endmodule
`default_nettype wire
